### sv/pla_pkg.sv
package pla_pkg;

	localparam int IDX_W = 7;

	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_BACK  = 3'd1;
	localparam logic [2:0] OP_INS_POS   = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_BACK  = 3'd4;
	localparam logic [2:0] OP_DUMP      = 3'd5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_SHIFT,
		CMD_ROTATE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic [IDX_W-1:0]   slot;
		logic [IDX_W-1:0]   count;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_DUMP = 2'b10
	} fsm_t;

endpackage

### sv/pla_cell.sv
module pla_cell import pla_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic signed [31:0] prev_data,
	input  logic signed [31:0] next_data,
	input  logic signed [31:0] bus_data,
	output logic signed [31:0] data_q
);

	localparam logic [IDX_W-1:0] SLOT = IDX_W'(IDX);

	logic signed [31:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctrl.cmd)
			CMD_INSERT: begin
				if (SLOT == ctrl.slot) begin
					data_d = bus_data;
				end else if (SLOT > ctrl.slot) begin
					data_d = prev_data;
				end
			end
			CMD_SHIFT: begin
				data_d = next_data;
			end
			CMD_ROTATE: begin
				// last live cell takes the old head, the rest move toward the front
				if (SLOT == ctrl.count - IDX_W'(1)) begin
					data_d = bus_data;
				end else begin
					data_d = next_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

### sv/positional_list_engine.sv
// Single-result requests: the result is registered in the cycle after acceptance.
// Dump of N elements: N results, each emitted when the output is free; the chain
// rotates once per result and holds its original order again after the last one.
// One request per cycle unless the output stalls or a dump is still emitting.
// arst_n clears count and control state; cells and result fields are not reset.
module positional_list_engine import pla_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] value,
	input  logic [5:0]         position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [5:0]         length,
	output logic signed [31:0] element,
	output logic               last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ((CW > 6) ? CW : 6) + 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	fsm_t               state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      rem_q, rem_d;
	logic               out_valid_q;
	logic [1:0]         status_q, status_d;
	logic [5:0]         length_q;
	logic signed [31:0] element_q, element_d;
	logic               last_q, last_d;
	logic               load;
	logic               accept;
	logic               emit;
	logic               slot_free;
	cell_ctrl_t         ctrl;
	logic signed [31:0] bus;
	logic signed [31:0] cell_data [CAPACITY];
	logic [PW-1:0]      pos_ext;
	logic [PW-1:0]      pos_lim;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == FSM_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign emit      = (state_q == FSM_DUMP) && slot_free;
	assign pos_ext   = PW'(position);
	assign pos_lim   = PW'(count_q) + PW'(1);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rem_d      = rem_q;
		load       = 1'b0;
		status_d   = ST_OK;
		element_d  = '0;
		last_d     = 1'b1;
		bus        = value;
		ctrl.cmd   = CMD_HOLD;
		ctrl.slot  = '0;
		ctrl.count = IDX_W'(count_q);
		if (accept) begin
			load = 1'b1;
			case (opcode)
				OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
					if (opcode == OP_INS_POS && (position == 6'd0 || pos_ext > pos_lim)) begin
						status_d = ST_BADPOS;
					end else if (count_q >= CAP_C) begin
						status_d = ST_FULL;
					end else begin
						ctrl.cmd = CMD_INSERT;
						if (opcode == OP_INS_FRONT) begin
							ctrl.slot = '0;
						end else if (opcode == OP_INS_BACK) begin
							ctrl.slot = IDX_W'(count_q);
						end else begin
							ctrl.slot = IDX_W'(position) - IDX_W'(1);
						end
						count_d = count_q + CW'(1);
					end
				end
				OP_DEL_FRONT: begin
					if (count_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						ctrl.cmd = CMD_SHIFT;
						count_d  = count_q - CW'(1);
					end
				end
				OP_DEL_BACK: begin
					if (count_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						count_d = count_q - CW'(1);
					end
				end
				OP_DUMP: begin
					if (count_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						load    = 1'b0;
						state_d = FSM_DUMP;
						rem_d   = count_q;
					end
				end
				default: begin
					status_d = ST_OK;
				end
			endcase
		end else if (emit) begin
			load      = 1'b1;
			element_d = cell_data[0];
			last_d    = (rem_q == CW'(1));
			bus       = cell_data[0];
			ctrl.cmd  = CMD_ROTATE;
			rem_d     = rem_q - CW'(1);
			if (rem_q == CW'(1)) begin
				state_d = FSM_IDLE;
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] prev_w;
		logic signed [31:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = bus;
		end else begin : g_prev
			assign prev_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign next_w = bus;
		end else begin : g_next
			assign next_w = cell_data[i+1];
		end
		pla_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.prev_data (prev_w),
			.next_data (next_w),
			.bus_data  (bus),
			.data_q    (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= status_d;
			length_q  <= 6'(count_d);
			element_q <= element_d;
			last_q    <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign length    = length_q;
	assign element   = element_q;
	assign last      = last_q;

endmodule

### sv/pla_checker.sv
module pla_checker import pla_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [5:0]         length,
	input logic signed [31:0] element,
	input logic               last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(length)
		&& $stable(element) && $stable(last))
		else $error("result changed while stalled");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, length} <= 7'(CAPACITY))
		else $error("length above capacity");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && element == 32'sd0)
		else $error("error result not final or carries element");

	// a dump result that is not final is followed by more without new requests
	a_dump_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("request taken in the middle of a dump");

endmodule

bind positional_list_engine pla_checker #(.CAPACITY(CAPACITY)) u_pla_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.length    (length),
	.element   (element),
	.last      (last)
);
